@@ rtl/point_projection_assert.svh @@
// ----------------------------------------------------------------------------
// point projection assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef POINT_PROJECTION_ASSERT_SVH
`define POINT_PROJECTION_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define PP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("point_projection: same-cycle check failed");

// next-cycle implication, clocked on i_clk, off during reset
`define PP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("point_projection: next-cycle check failed");

`endif

@@ rtl/pp_pkg.sv @@
// ----------------------------------------------------------------------------
// point projection package
// widths, register codes and pipeline stage types
// ----------------------------------------------------------------------------
package pp_pkg;

    localparam int COORD_W         = 32;
    localparam int COLOR_W         = 16;
    localparam int PROD_W          = 48;  // q32.32 product floored to q.16
    localparam int SUM_W           = 52;  // four-term sum, signed
    localparam int QBITS           = 12;  // pixel field width
    localparam int SIZE_W          = 13;
    localparam int MAX_SCREEN_SIZE = 4096;
    localparam int CFG_DW          = 64;
    localparam int ADDR_W          = 6;
    localparam int DIV_W           = SUM_W + QBITS;

    typedef enum logic [2:0] {
        REG_ROW_X_COLS01 = 3'd0,
        REG_ROW_X_COLS23 = 3'd1,
        REG_ROW_Y_COLS01 = 3'd2,
        REG_ROW_Y_COLS23 = 3'd3,
        REG_ROW_W_COLS01 = 3'd4,
        REG_ROW_W_COLS23 = 3'd5,
        REG_SCREEN_WIDTH = 3'd6,
        REG_SCREEN_HEIGHT = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_color;

    // one item in the divide pipeline
    typedef struct packed {
        logic [SUM_W-1:0] rem_x;
        logic [SUM_W-1:0] rem_y;
        logic [SUM_W-1:0] den;
        logic [QBITS-1:0] q_x;
        logic [QBITS-1:0] q_y;
        logic             neg_x;
        logic             neg_y;
        logic             big_x;
        logic             big_y;
        logic             w_zero;
        t_color           color;
    } t_div;

endpackage

@@ rtl/pp_in_if.sv @@
// ----------------------------------------------------------------------------
// point projection input channel
// valid/ready stream carrying one point and its color
// ----------------------------------------------------------------------------
interface pp_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [pp_pkg::COORD_W-1:0]   pos_x;
    logic signed [pp_pkg::COORD_W-1:0]   pos_y;
    logic signed [pp_pkg::COORD_W-1:0]   pos_z;
    logic        [pp_pkg::COLOR_W-1:0]   color_red;
    logic        [pp_pkg::COLOR_W-1:0]   color_green;
    logic        [pp_pkg::COLOR_W-1:0]   color_blue;

    modport source (output valid, pos_x, pos_y, pos_z, color_red, color_green, color_blue,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, color_red, color_green, color_blue,
                    output ready);
endinterface

@@ rtl/pp_out_if.sv @@
// ----------------------------------------------------------------------------
// point projection output channel
// valid/ready stream carrying one projected pixel
// ----------------------------------------------------------------------------
interface pp_out_if;
    logic                          valid;
    logic                          ready;
    logic                          visible;
    logic [pp_pkg::QBITS-1:0]      pixel_x;
    logic [pp_pkg::QBITS-1:0]      pixel_y;
    logic [pp_pkg::COLOR_W-1:0]    out_red;
    logic [pp_pkg::COLOR_W-1:0]    out_green;
    logic [pp_pkg::COLOR_W-1:0]    out_blue;

    modport source (output valid, visible, pixel_x, pixel_y, out_red, out_green, out_blue,
                    input ready);
    modport sink   (input valid, visible, pixel_x, pixel_y, out_red, out_green, out_blue,
                    output ready);
endinterface

@@ rtl/point_projection.sv @@
// throughput: one item per cycle; the whole pipeline advances together and
//   holds in place while a finished result is not taken
// the 12-stage restoring divider (one quotient bit per stage) sets the depth
// reset: synchronous active-low, clears all valid bits and loads the matrix
//   and screen registers with their identity/default values
// ----------------------------------------------------------------------------
// point projection
// homogeneous point transform with perspective divide and screen clip
// ----------------------------------------------------------------------------
`include "point_projection_assert.svh"

module point_projection (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    pp_in_if.sink                         i_in,
    pp_out_if.source                      o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pp_pkg::ADDR_W-1:0]     paddr,
    input  logic [pp_pkg::CFG_DW-1:0]     pwdata,
    output logic [pp_pkg::CFG_DW-1:0]     prdata,
    output logic                          pready
);

    localparam int NDIV = pp_pkg::QBITS;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [pp_pkg::CFG_DW-1:0] r_row [0:5];
    logic [pp_pkg::SIZE_W-1:0] r_width;
    logic [pp_pkg::SIZE_W-1:0] r_height;
    logic [2:0]                cfg_idx;
    logic                      cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= 64'h0000_0000_0001_0000;
            r_row[1] <= '0;
            r_row[2] <= 64'h0001_0000_0000_0000;
            r_row[3] <= '0;
            r_row[4] <= '0;
            r_row[5] <= 64'h0001_0000_0000_0000;
            r_width  <= pp_pkg::SIZE_W'(1024);
            r_height <= pp_pkg::SIZE_W'(768);
        end else if (cfg_wr) begin
            case (pp_pkg::t_reg_idx'(cfg_idx))
                pp_pkg::REG_ROW_X_COLS01:  r_row[0] <= pwdata;
                pp_pkg::REG_ROW_X_COLS23:  r_row[1] <= pwdata;
                pp_pkg::REG_ROW_Y_COLS01:  r_row[2] <= pwdata;
                pp_pkg::REG_ROW_Y_COLS23:  r_row[3] <= pwdata;
                pp_pkg::REG_ROW_W_COLS01:  r_row[4] <= pwdata;
                pp_pkg::REG_ROW_W_COLS23:  r_row[5] <= pwdata;
                pp_pkg::REG_SCREEN_WIDTH:  r_width  <= pwdata[pp_pkg::SIZE_W-1:0];
                pp_pkg::REG_SCREEN_HEIGHT: r_height <= pwdata[pp_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (pp_pkg::t_reg_idx'(cfg_idx))
            pp_pkg::REG_ROW_X_COLS01:  prdata = r_row[0];
            pp_pkg::REG_ROW_X_COLS23:  prdata = r_row[1];
            pp_pkg::REG_ROW_Y_COLS01:  prdata = r_row[2];
            pp_pkg::REG_ROW_Y_COLS23:  prdata = r_row[3];
            pp_pkg::REG_ROW_W_COLS01:  prdata = r_row[4];
            pp_pkg::REG_ROW_W_COLS23:  prdata = r_row[5];
            pp_pkg::REG_SCREEN_WIDTH:  prdata = {51'd0, r_width};
            pp_pkg::REG_SCREEN_HEIGHT: prdata = {51'd0, r_height};
            default:                   prdata = '0;
        endcase
    end

    // effective screen size, limited to the pixel field range
    logic [pp_pkg::SIZE_W-1:0] w_size;
    logic [pp_pkg::SIZE_W-1:0] h_size;
    assign w_size = (r_width  > pp_pkg::SIZE_W'(pp_pkg::MAX_SCREEN_SIZE)) ?
                    pp_pkg::SIZE_W'(pp_pkg::MAX_SCREEN_SIZE) : r_width;
    assign h_size = (r_height > pp_pkg::SIZE_W'(pp_pkg::MAX_SCREEN_SIZE)) ?
                    pp_pkg::SIZE_W'(pp_pkg::MAX_SCREEN_SIZE) : r_height;

    // coefficient c of row r (rows: x, y, w)
    logic signed [31:0] coef [0:2][0:3];
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            coef[r][0] = r_row[2*r][31:0];
            coef[r][1] = r_row[2*r][63:32];
            coef[r][2] = r_row[2*r+1][31:0];
            coef[r][3] = r_row[2*r+1][63:32];
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: one enable for every stage
    // ------------------------------------------------------------------
    logic r_out_vld;
    logic en;
    assign en         = !r_out_vld || o_out.ready;
    assign i_in.ready = en;

    // valid bits: input reg, products, sums, abs/range, divider stages
    localparam int NVLD = 4 + NDIV;
    logic [NVLD-1:0] r_vld;
    logic [NVLD-1:0] n_vld;
    assign n_vld = {r_vld[NVLD-2:0], i_in.valid};

    // ------------------------------------------------------------------
    // stage 1: input register
    // ------------------------------------------------------------------
    logic signed [31:0] r_pos [0:2];
    pp_pkg::t_color     r_col1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pos[0] <= i_in.pos_x;
            r_pos[1] <= i_in.pos_y;
            r_pos[2] <= i_in.pos_z;
            r_col1   <= '{i_in.color_red, i_in.color_green, i_in.color_blue};
        end
    end

    // ------------------------------------------------------------------
    // stage 2: nine 32x32 products, floored to q.16 (arithmetic shift)
    // ------------------------------------------------------------------
    logic signed [pp_pkg::PROD_W-1:0] r_prod [0:2][0:2];
    pp_pkg::t_color                   r_col2;
    logic signed [63:0]               n_prod [0:2][0:2];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_prod[r][c] = 64'(coef[r][c]) * 64'(r_pos[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r][c] <= n_prod[r][c][63:16];
                end
            end
            r_col2 <= r_col1;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: row sums X, Y, W plus the translation column
    // ------------------------------------------------------------------
    logic signed [pp_pkg::SUM_W-1:0] r_sum [0:2];
    pp_pkg::t_color                  r_col3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                r_sum[r] <= pp_pkg::SUM_W'(r_prod[r][0]) + pp_pkg::SUM_W'(r_prod[r][1])
                          + pp_pkg::SUM_W'(r_prod[r][2]) + pp_pkg::SUM_W'(coef[r][3]);
            end
            r_col3 <= r_col2;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: magnitudes, signs, quotient overflow (|num| >= 4096*|w|)
    // ------------------------------------------------------------------
    pp_pkg::t_div r_div [0:NDIV];

    logic [pp_pkg::SUM_W-1:0] abs_x;
    logic [pp_pkg::SUM_W-1:0] abs_y;
    logic [pp_pkg::SUM_W-1:0] abs_w;
    assign abs_x = r_sum[0][pp_pkg::SUM_W-1] ? -r_sum[0] : r_sum[0];
    assign abs_y = r_sum[1][pp_pkg::SUM_W-1] ? -r_sum[1] : r_sum[1];
    assign abs_w = r_sum[2][pp_pkg::SUM_W-1] ? -r_sum[2] : r_sum[2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_div[0].rem_x  <= abs_x;
            r_div[0].rem_y  <= abs_y;
            r_div[0].den    <= abs_w;
            r_div[0].q_x    <= '0;
            r_div[0].q_y    <= '0;
            r_div[0].neg_x  <= r_sum[0][pp_pkg::SUM_W-1] ^ r_sum[2][pp_pkg::SUM_W-1];
            r_div[0].neg_y  <= r_sum[1][pp_pkg::SUM_W-1] ^ r_sum[2][pp_pkg::SUM_W-1];
            r_div[0].big_x  <= pp_pkg::DIV_W'(abs_x) >= {abs_w, 12'd0};
            r_div[0].big_y  <= pp_pkg::DIV_W'(abs_y) >= {abs_w, 12'd0};
            r_div[0].w_zero <= (r_sum[2] == '0);
            r_div[0].color  <= r_col3;
        end
    end

    // ------------------------------------------------------------------
    // restoring divider, one quotient bit per stage, msb first
    // remainder stays below den << (k+1), so it fits in SUM_W bits
    // ------------------------------------------------------------------
    for (genvar j = 0; j < NDIV; j++) begin : g_div
        localparam int K = NDIV - 1 - j;
        logic [pp_pkg::DIV_W-1:0] sh_den;
        logic                     ge_x;
        logic                     ge_y;
        pp_pkg::t_div             n_div;

        assign sh_den = pp_pkg::DIV_W'(r_div[j].den) << K;
        assign ge_x   = pp_pkg::DIV_W'(r_div[j].rem_x) >= sh_den;
        assign ge_y   = pp_pkg::DIV_W'(r_div[j].rem_y) >= sh_den;

        always_comb begin
            n_div       = r_div[j];
            n_div.rem_x = ge_x ? pp_pkg::SUM_W'(pp_pkg::DIV_W'(r_div[j].rem_x) - sh_den)
                               : r_div[j].rem_x;
            n_div.rem_y = ge_y ? pp_pkg::SUM_W'(pp_pkg::DIV_W'(r_div[j].rem_y) - sh_den)
                               : r_div[j].rem_y;
            n_div.q_x   = {r_div[j].q_x[NDIV-2:0], ge_x};
            n_div.q_y   = {r_div[j].q_y[NDIV-2:0], ge_y};
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_div[j+1] <= n_div;
            end
        end
    end

    // ------------------------------------------------------------------
    // output stage: clip test and result register
    // a negative quotient that truncates to zero still counts as on screen
    // ------------------------------------------------------------------
    pp_pkg::t_div fin;
    logic         ok_x;
    logic         ok_y;
    logic         n_vis;
    assign fin   = r_div[NDIV];
    assign ok_x  = !fin.big_x && (!fin.neg_x || fin.q_x == '0)
                   && ({1'b0, fin.q_x} < w_size);
    assign ok_y  = !fin.big_y && (!fin.neg_y || fin.q_y == '0)
                   && ({1'b0, fin.q_y} < h_size);
    assign n_vis = !fin.w_zero && ok_x && ok_y;

    logic                    r_vis;
    logic [NDIV-1:0]         r_px;
    logic [NDIV-1:0]         r_py;
    pp_pkg::t_color          r_ocol;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vis  <= n_vis;
            r_px   <= n_vis ? fin.q_x : '0;
            r_py   <= n_vis ? fin.q_y : '0;
            r_ocol <= fin.color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= n_vld;
            r_out_vld <= r_vld[NVLD-1];
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.visible   = r_vis;
    assign o_out.pixel_x   = r_px;
    assign o_out.pixel_y   = r_py;
    assign o_out.out_red   = r_ocol.red;
    assign o_out.out_green = r_ocol.green;
    assign o_out.out_blue  = r_ocol.blue;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `PP_ASSERT_IMPL(a_vis_in_width, o_out.valid && o_out.visible,
                    ({1'b0, o_out.pixel_x} < w_size) && ({1'b0, o_out.pixel_y} < h_size))
    `PP_ASSERT_IMPL(a_hidden_zero, o_out.valid && !o_out.visible,
                    o_out.pixel_x == '0 && o_out.pixel_y == '0)
    `PP_ASSERT_NEXT(a_stall_holds, !en, $stable(r_vld) && $stable(r_out_vld))

endmodule
